### rtl/imu_fp_pkg.sv
package imu_fp_pkg;

  localparam int unsigned FrameLen   = 11;
  localparam int unsigned SumLen     = 10;
  localparam int unsigned CountW     = 4;
  localparam logic [7:0]  HeaderByte = 8'h55;
  localparam int unsigned InDataW    = 8;
  localparam int unsigned OutDataW   = 72;

  typedef struct packed {
    logic               hit;
    logic [7:0]         frame_type;
    logic signed [15:0] word_a;
    logic signed [15:0] word_b;
    logic signed [15:0] word_c;
    logic signed [15:0] word_d;
  } frame_res_t;

endpackage

### rtl/imu_fp_core.sv
module imu_fp_core (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic [7:0]              byte_i,
  output imu_fp_pkg::frame_res_t  res_o
);

  localparam int unsigned FL = imu_fp_pkg::FrameLen;
  localparam int unsigned SL = imu_fp_pkg::SumLen;
  localparam int unsigned CW = imu_fp_pkg::CountW;

  logic [7:0]    buf_q [FL];
  logic [7:0]    buf_d [FL];
  logic [7:0]    nb    [FL];
  logic [7:0]    pair  [SL/2];
  logic [CW-1:0] cnt_q, cnt_d, cnt_eff;
  logic [7:0]    sum;
  logic          head_ok, full, match;

  always_comb begin
    cnt_eff = (cnt_q >= CW'(FL)) ? '0 : cnt_q;
    for (int i = 0; i < FL; i++) begin
      nb[i] = (CW'(i) == cnt_eff) ? byte_i : buf_q[i];
    end
    for (int i = 0; i < SL/2; i++) begin
      pair[i] = nb[2*i] + nb[2*i+1];
    end
    sum     = (pair[0] + pair[1]) + (pair[2] + pair[3]) + pair[4];
    head_ok = (nb[0] == imu_fp_pkg::HeaderByte);
    full    = (cnt_eff == CW'(SL));
    match   = head_ok && full && (sum == nb[SL]);
  end

  // drop the oldest byte on a bad header or a checksum mismatch
  always_comb begin
    buf_d = nb;
    cnt_d = cnt_eff + CW'(1);
    if (!head_ok || (full && !match)) begin
      for (int i = 0; i < FL - 1; i++) begin
        buf_d[i] = nb[i+1];
      end
      cnt_d = cnt_eff;
    end else if (match) begin
      cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      buf_q <= buf_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (en_i) begin
      cnt_q <= cnt_d;
    end
  end

  always_comb begin
    res_o.hit        = match;
    res_o.frame_type = nb[1];
    res_o.word_a     = {nb[3], nb[2]};
    res_o.word_b     = {nb[5], nb[4]};
    res_o.word_c     = {nb[7], nb[6]};
    res_o.word_d     = {nb[9], nb[8]};
  end

endmodule

### rtl/imu_serial_frame_parser.sv
// Input byte and result are both registered. Throughput: one byte per cycle
// unless the output stalls; the frame buffer update and the 10-byte checksum
// run in a single stage between the input and the result register.
// Reset: clears the fill count and both valid flags at once; the frame buffer
// content is undefined until written.
module imu_serial_frame_parser (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [imu_fp_pkg::InDataW-1:0]      s_axis_tdata,   // rx_byte
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // frame_type[7:0], word_a[23:8], word_b[39:24], word_c[55:40], word_d[71:56]
  output logic [imu_fp_pkg::OutDataW-1:0]     m_axis_tdata
);

  logic                                   in_valid_q;
  logic [7:0]                             in_byte_q;
  logic                                   out_valid_q;
  logic [imu_fp_pkg::OutDataW-1:0]        out_data_q;
  logic                                   advance;
  imu_fp_pkg::frame_res_t                 res;

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  imu_fp_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (in_valid_q && advance),
    .byte_i (in_byte_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q && res.hit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q && res.hit) begin
      out_data_q <= {res.word_d, res.word_c, res.word_b, res.word_a, res.frame_type};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

### rtl/imu_fp_checker.sv
module imu_fp_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [imu_fp_pkg::OutDataW-1:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  a_result_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result without a byte two cycles earlier");

endmodule

bind imu_serial_frame_parser imu_fp_checker u_imu_fp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
